>>> hdl/cptl_pkg.sv
// shared constants, codes and field layout for the change point table lookup unit
package cptl_pkg;

   // default sizing handed to the top-level parameters
   localparam int DEF_MAX_ENTRIES  = 1024;
   localparam int DEF_CHUNK_CYCLES = 1024;
   localparam int DEF_KEY_BITS     = 16;

   // fixed field widths of the stream payloads
   localparam int MODE_W   = 2;
   localparam int OFFSET_W = 10;
   localparam int KEY_W    = 16;
   localparam int CYCLE_W  = 31;
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 10;

   // request tdata layout: entry_offset, entry_key, query_cycle
   localparam int REQ_OFF_LSB   = 0;
   localparam int REQ_KEY_LSB   = REQ_OFF_LSB + OFFSET_W;
   localparam int REQ_QUERY_LSB = REQ_KEY_LSB + KEY_W;
   localparam int REQ_DATA_W    = 64;

   // response tdata layout: found_key, found_cycle, found_index
   localparam int RSP_KEY_LSB   = 0;
   localparam int RSP_CYCLE_LSB = RSP_KEY_LSB + KEY_W;
   localparam int RSP_INDEX_LSB = RSP_CYCLE_LSB + CYCLE_W;
   localparam int RSP_DATA_W    = 64;

   // configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_CYCLE    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNDEFINED_KEY = 4'd1;
   localparam logic [KEY_W-1:0]       UNDEF_KEY_RESET   = 16'hFFFF;

   // request kinds
   typedef enum logic [MODE_W-1:0] {
      MODE_APPEND = 2'd0,
      MODE_LOOKUP = 2'd1,
      MODE_CLEAR  = 2'd2,
      MODE_SPARE  = 2'd3
   } mode_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_FOUND     = 3'd0,
      STATUS_UNDEF     = 3'd1,
      STATUS_NOT_FOUND = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_ORDER     = 3'd4
   } status_type;

endpackage

>>> hdl/cptl_ram.sv
// generic single-clock ram with one write port and one registered read port
module cptl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/change_point_table_lookup_unit.sv
// change point table: ordered append, clear and binary-search predecessor lookup
//
// Usage:
//   req_*  stream carries one command beat; tuser selects append, lookup or
//          clear. Every command beat gives exactly one rsp_* beat, in order.
//   rsp_*  stream carries status in tuser and key, cycle and index in tdata.
//   csr_*  write port for base_cycle (index 0) and undefined_key (index 1);
//          always ready; the user must write only while idle; not enforced.
// Flow after accept:
//   append: check state, then result stage; a full table or an offset past
//   the chunk, and clear and spare kind, go straight to the result stage.
//   lookup: one search state and offset ram read per binary-search probe, then
//   fetch if found, then result; empty table or cycle before base: result only.
// One command is in flight at a time; req_tready rises again as the result
// moves into the output register, together with rsp_tvalid.
// Reset empties the table (entry count only), sets base_cycle to 0 and
// undefined_key to all ones. A stalled receiver holds the output register;
// the next command may still be taken and waits at its result stage.
module change_point_table_lookup_unit #(
   parameter int MAX_ENTRIES  = cptl_pkg::DEF_MAX_ENTRIES,
   parameter int CHUNK_CYCLES = cptl_pkg::DEF_CHUNK_CYCLES,
   parameter int KEY_BITS     = cptl_pkg::DEF_KEY_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   // command stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: entry_offset[9:0], entry_key[25:10], query_cycle[56:26], zero fill
   input  logic [cptl_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: mode[1:0]
   input  logic [cptl_pkg::MODE_W-1:0]        req_tuser,
   // response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: found_key[15:0], found_cycle[46:16], found_index[56:47], zero fill
   output logic [cptl_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // tuser: status[2:0]
   output logic [cptl_pkg::STATUS_W-1:0]      rsp_tuser,
   // configuration writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cptl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [cptl_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import cptl_pkg::*;

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int OFS_W = $clog2(CHUNK_CYCLES);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APP_CHK,
      ST_SEARCH,
      ST_FETCH,
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [OFFSET_W-1:0]   off_ff, off_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [CYCLE_W-1:0]    rel_ff, rel_in;
   logic [CYCLE_W-1:0]    base_ff, base_in;
   logic [KEY_W-1:0]      undef_ff, undef_in;
   status_type            res_status_ff, res_status_in;
   logic [KEY_W-1:0]      res_key_ff, res_key_in;
   logic [CYCLE_W-1:0]    res_cycle_ff, res_cycle_in;
   logic [INDEX_W-1:0]    res_index_ff, res_index_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]   rsp_user_ff, rsp_user_in;

   // request fields
   mode_type              req_mode;
   logic [OFFSET_W-1:0]   req_off;
   logic [KEY_W-1:0]      req_key;
   logic [CYCLE_W-1:0]    req_query;
   logic [31:0]           req_key_ext;
   logic                  req_beat;

   // ram ports
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [IDX_W-1:0]      rd_addr;
   logic [OFS_W-1:0]      ofs_rd;
   logic [KEY_BITS-1:0]   key_rd;

   // shared adder / subtractor
   logic [31:0]           alu_a, alu_b, alu_res;
   logic                  alu_sub;

   // search step
   logic                  probe_le;
   logic [CNT_W-1:0]      lo_nx, hi_nx, mid_nx, last_nx;

   // width helpers
   logic [31:0]           key_rd_ext, undef_ext, idx_ext, cnt_ext;
   logic [KEY_BITS-1:0]   undef_masked;

   assign req_mode    = mode_type'(req_tuser);
   assign req_off     = req_tdata[REQ_OFF_LSB +: OFFSET_W];
   assign req_key     = req_tdata[REQ_KEY_LSB +: KEY_W];
   assign req_query   = req_tdata[REQ_QUERY_LSB +: CYCLE_W];
   assign req_key_ext = 32'(req_key);
   assign req_beat    = req_tvalid && req_tready;

   assign key_rd_ext   = 32'(key_rd);
   assign undef_ext    = 32'(undef_ff);
   assign undef_masked = undef_ext[KEY_BITS-1:0];
   assign idx_ext      = 32'(mid_ff);
   assign cnt_ext      = 32'(cnt_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // offset and key stores
   cptl_ram #(.WIDTH(OFS_W), .DEPTH(MAX_ENTRIES)) u_ofs_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (OFS_W'(off_ff)),
      .rd_addr (rd_addr),
      .rd_data (ofs_rd)
   );

   cptl_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (key_ff),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   // operand select for the shared adder
   always_comb begin
      alu_sub = 1'b0;
      alu_a   = 32'(base_ff);
      alu_b   = 32'(off_ff);
      unique case (state_ff)
         ST_IDLE: begin
            alu_sub = 1'b1;
            alu_a   = 32'(req_query);
            alu_b   = 32'(base_ff);
         end
         ST_FETCH: begin
            alu_b = 32'(ofs_rd);
         end
         default: begin
         end
      endcase
   end

   assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

   // one binary-search probe: narrow [lo, hi) around the entry read at mid
   assign probe_le = (CYCLE_W'(ofs_rd) <= rel_ff);
   assign lo_nx    = probe_le ? (mid_ff + CNT_W'(1)) : lo_ff;
   assign hi_nx    = probe_le ? hi_ff : mid_ff;
   assign mid_nx   = lo_nx + ((hi_nx - lo_nx) >> 1);
   assign last_nx  = lo_nx - CNT_W'(1);

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      off_in        = off_ff;
      key_in        = key_ff;
      rel_in        = rel_ff;
      base_in       = base_ff;
      undef_in      = undef_ff;
      res_status_in = res_status_ff;
      res_key_in    = res_key_ff;
      res_cycle_in  = res_cycle_ff;
      res_index_in  = res_index_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      wr_en         = 1'b0;
      wr_addr       = cnt_ff[IDX_W-1:0];
      rd_addr       = mid_ff[IDX_W-1:0];

      // register writes
      if (csr_valid) begin
         case (csr_index)
            CSR_BASE_CYCLE:    base_in  = csr_wdata[CYCLE_W-1:0];
            CSR_UNDEFINED_KEY: undef_in = csr_wdata[KEY_W-1:0];
            default: begin
            end
         endcase
      end

      // output register drains
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               res_status_in = STATUS_FOUND;
               res_key_in    = '0;
               res_cycle_in  = '0;
               res_index_in  = '0;
               state_in      = ST_DONE;
               unique case (req_mode)
                  MODE_APPEND: begin
                     off_in  = req_off;
                     key_in  = req_key_ext[KEY_BITS-1:0];
                     rd_addr = IDX_W'(cnt_ff - CNT_W'(1));
                     if (cnt_ff == CNT_W'(MAX_ENTRIES)) begin
                        res_status_in = STATUS_FULL;
                     end else if (32'(req_off) >= 32'(CHUNK_CYCLES)) begin
                        res_status_in = STATUS_ORDER;
                     end else begin
                        state_in = ST_APP_CHK;
                     end
                  end
                  MODE_LOOKUP: begin
                     rel_in = alu_res[CYCLE_W-1:0];
                     if (cnt_ff == '0 || alu_res[31]) begin
                        res_status_in = STATUS_NOT_FOUND;
                     end else begin
                        lo_in    = '0;
                        hi_in    = cnt_ff;
                        mid_in   = cnt_ff >> 1;
                        rd_addr  = IDX_W'(cnt_ff >> 1);
                        state_in = ST_SEARCH;
                     end
                  end
                  MODE_CLEAR: begin
                     cnt_in = '0;
                  end
                  MODE_SPARE: begin
                     res_status_in = STATUS_NOT_FOUND;
                  end
               endcase
            end
         end

         // last stored offset is on the ram output; store if rising
         ST_APP_CHK: begin
            if (cnt_ff != '0 && 32'(off_ff) <= 32'(ofs_rd)) begin
               res_status_in = STATUS_ORDER;
            end else begin
               wr_en         = 1'b1;
               res_status_in = STATUS_FOUND;
               res_key_in    = KEY_W'(32'(key_ff));
               res_cycle_in  = alu_res[CYCLE_W-1:0];
               res_index_in  = cnt_ext[INDEX_W-1:0];
               cnt_in        = cnt_ff + CNT_W'(1);
            end
            state_in = ST_DONE;
         end

         ST_SEARCH: begin
            if (lo_nx < hi_nx) begin
               lo_in   = lo_nx;
               hi_in   = hi_nx;
               mid_in  = mid_nx;
               rd_addr = mid_nx[IDX_W-1:0];
            end else if (lo_nx == '0) begin
               res_status_in = STATUS_NOT_FOUND;
               state_in      = ST_DONE;
            end else begin
               mid_in   = last_nx;
               rd_addr  = last_nx[IDX_W-1:0];
               state_in = ST_FETCH;
            end
         end

         // predecessor entry is on the ram outputs
         ST_FETCH: begin
            res_status_in = (key_rd == undef_masked) ? STATUS_UNDEF : STATUS_FOUND;
            res_key_in    = key_rd_ext[KEY_W-1:0];
            res_cycle_in  = alu_res[CYCLE_W-1:0];
            res_index_in  = idx_ext[INDEX_W-1:0];
            state_in      = ST_DONE;
         end

         // hand the result to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = res_status_ff;
               rsp_data_in  = '0;
               rsp_data_in[RSP_KEY_LSB +: KEY_W]     = res_key_ff;
               rsp_data_in[RSP_CYCLE_LSB +: CYCLE_W] = res_cycle_ff;
               rsp_data_in[RSP_INDEX_LSB +: INDEX_W] = res_index_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         undef_ff     <= UNDEF_KEY_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         undef_ff     <= undef_in;
      end
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      off_ff        <= off_in;
      key_ff        <= key_in;
      rel_ff        <= rel_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      res_cycle_ff  <= res_cycle_in;
      res_index_ff  <= res_index_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   // entry count stays within the table
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count beyond table size");

   // count only steps up by one or drops to zero on a clear
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != $past(cnt_ff)) |->
         (cnt_ff == $past(cnt_ff) + CNT_W'(1)) || (cnt_ff == '0))
      else $error("entry count moved by more than one");

   // the search window is never empty while probing
   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (lo_ff < hi_ff) && (hi_ff <= cnt_ff))
      else $error("binary search window out of range");

   // a result waiting on a stalled output register is not dropped
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_tready) |=> (state_ff == ST_DONE))
      else $error("result left before output register was free");

endmodule

>>> bench/change_point_table_lookup_checker.sv
`timescale 1ns / 100ps
// result checker for the change point table: shadow table, lookup prediction and compare
module change_point_table_lookup_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [cptl_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [cptl_pkg::MODE_W-1:0]      req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [cptl_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic [cptl_pkg::STATUS_W-1:0]    rsp_tuser,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [cptl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cptl_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               mismatch_count,
   output int                               results_owed
);

   import cptl_pkg::*;

   localparam int TABLE_DEPTH = DEF_MAX_ENTRIES;
   localparam int CHUNK_LIMIT = DEF_CHUNK_CYCLES;

   typedef struct packed {
      status_type           status;
      logic [KEY_W-1:0]     key;
      logic [CYCLE_W-1:0]   cycle;
      logic [INDEX_W-1:0]   index;
   } table_answer_type;

   // shadow copy of the change point table and its registers
   logic [OFFSET_W-1:0] offset_shadow [TABLE_DEPTH];
   logic [KEY_W-1:0]    key_shadow [TABLE_DEPTH];
   int                  entry_total = 0;
   logic [CYCLE_W-1:0]  base_cycle_reg = '0;
   logic [KEY_W-1:0]    undef_key_reg = UNDEF_KEY_RESET;

   table_answer_type answers_due [$];
   int               error_total = 0;
   int               owed_total = 0;

   assign mismatch_count = error_total;
   assign results_owed   = owed_total;

   // apply one command to the shadow table and work out its response
   function automatic table_answer_type apply_command(input logic [MODE_W-1:0]   mode,
                                                      input logic [OFFSET_W-1:0] off,
                                                      input logic [KEY_W-1:0]    key,
                                                      input logic [CYCLE_W-1:0]  query);
      table_answer_type   ans;
      logic [CYCLE_W-1:0] rel;
      int                 lo;
      int                 hi;
      int                 mid;
      ans = '0;
      ans.status = STATUS_NOT_FOUND;
      case (mode_type'(mode))
         MODE_APPEND: begin
            if (entry_total >= TABLE_DEPTH) begin
               ans.status = STATUS_FULL;
            end else if (int'(off) >= CHUNK_LIMIT ||
                         (entry_total > 0 && off <= offset_shadow[entry_total-1])) begin
               ans.status = STATUS_ORDER;
            end else begin
               offset_shadow[entry_total] = off;
               key_shadow[entry_total]    = key;
               ans.status = STATUS_FOUND;
               ans.key    = key;
               ans.cycle  = base_cycle_reg + CYCLE_W'(off);
               ans.index  = INDEX_W'(entry_total);
               entry_total++;
            end
         end
         MODE_LOOKUP: begin
            // predecessor search: last entry with offset at or below the relative cycle
            if (entry_total > 0 && query >= base_cycle_reg) begin
               rel = query - base_cycle_reg;
               lo  = 0;
               hi  = entry_total;
               while (lo < hi) begin
                  mid = lo + (hi - lo) / 2;
                  if (CYCLE_W'(offset_shadow[mid]) <= rel) lo = mid + 1;
                  else hi = mid;
               end
               if (lo > 0) begin
                  ans.status = (key_shadow[lo-1] == undef_key_reg) ?
                               STATUS_UNDEF : STATUS_FOUND;
                  ans.key    = key_shadow[lo-1];
                  ans.cycle  = base_cycle_reg + CYCLE_W'(offset_shadow[lo-1]);
                  ans.index  = INDEX_W'(lo - 1);
               end
            end
         end
         MODE_CLEAR: begin
            entry_total = 0;
            ans.status  = STATUS_FOUND;
         end
         default: begin
         end
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      table_answer_type want;
      table_answer_type seen;
      if (reset) begin
         entry_total    = 0;
         base_cycle_reg = '0;
         undef_key_reg  = UNDEF_KEY_RESET;
         answers_due.delete();
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BASE_CYCLE:    base_cycle_reg = csr_wdata[CYCLE_W-1:0];
               CSR_UNDEFINED_KEY: undef_key_reg  = csr_wdata[KEY_W-1:0];
               default: begin
               end
            endcase
         end
         // response beat against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            seen.status = status_type'(rsp_tuser);
            seen.key    = rsp_tdata[RSP_KEY_LSB +: KEY_W];
            seen.cycle  = rsp_tdata[RSP_CYCLE_LSB +: CYCLE_W];
            seen.index  = rsp_tdata[RSP_INDEX_LSB +: INDEX_W];
            if (answers_due.size() == 0) begin
               if (error_total < 10)
                  $display({"%0t: response beat with nothing expected: ",
                            "status %0d key %h cycle %h index %0d"},
                           $time, seen.status, seen.key, seen.cycle, seen.index);
               error_total++;
            end else begin
               want = answers_due.pop_front();
               if (seen.status !== want.status || seen.key !== want.key ||
                   seen.cycle !== want.cycle || seen.index !== want.index) begin
                  if (error_total < 10)
                     $display({"%0t: mismatch: expected status %0d key %h cycle %h ",
                               "index %0d, got status %0d key %h cycle %h index %0d"},
                              $time, want.status, want.key, want.cycle, want.index,
                              seen.status, seen.key, seen.cycle, seen.index);
                  error_total++;
               end
            end
         end
         // command beat into the shadow table
         if (req_tvalid && req_tready)
            answers_due.push_back(apply_command(req_tuser,
                                                req_tdata[REQ_OFF_LSB +: OFFSET_W],
                                                req_tdata[REQ_KEY_LSB +: KEY_W],
                                                req_tdata[REQ_QUERY_LSB +: CYCLE_W]));
      end
      owed_total <= answers_due.size();
   end

endmodule

>>> bench/change_point_table_lookup_unit_tb.sv
`timescale 1ns / 100ps
// testbench top for the change point table lookup unit: stimulus, pacing and verdict
module change_point_table_lookup_unit_tb;
   import cptl_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [MODE_W-1:0]      req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [STATUS_W-1:0]    rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int mismatch_count;
   int results_owed;

   // stimulus shaping state
   bit                 no_idle = 1'b0;
   bit                 hold_request = 1'b0;
   int                 next_offset = 0;
   logic [CYCLE_W-1:0] cur_base = '0;
   logic [KEY_W-1:0]   cur_undef = UNDEF_KEY_RESET;

   always #5 clock = ~clock;

   change_point_table_lookup_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   change_point_table_lookup_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   // one command beat; valid stays high when the next beat follows without a gap
   task automatic send_command(input mode_type mode, input logic [OFFSET_W-1:0] off,
                               input logic [KEY_W-1:0] key, input logic [CYCLE_W-1:0] query);
      int gap;
      gap = no_idle ? 0 : $urandom_range(19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {7'b0, query, key, off};
      do @(posedge clock); while (!req_tready);
   endtask

   // drop valid and wait until every response has come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
   endtask

   // write both registers back to back
   task automatic set_table_config(input logic [CYCLE_W-1:0] base, input logic [KEY_W-1:0] undef);
      csr_valid <= 1'b1;
      csr_index <= CSR_BASE_CYCLE;
      csr_wdata <= {1'b0, base};
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_UNDEFINED_KEY;
      csr_wdata <= {16'b0, undef};
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_base  = base;
      cur_undef = undef;
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(99) < 20) return cur_undef;
      return KEY_W'($urandom);
   endfunction

   // query cycles: mostly near the stored offsets, some below base, some anywhere
   function automatic logic [CYCLE_W-1:0] pick_query();
      int unsigned pick;
      logic [31:0] sum;
      pick = $urandom_range(99);
      if (pick < 15) return CYCLE_W'($urandom);
      if (pick < 30 && cur_base > 0) return CYCLE_W'($urandom_range(cur_base - 1));
      sum = {1'b0, cur_base} + $urandom_range(next_offset + 8);
      return (sum > 32'h7FFF_FFFF) ? 31'h7FFF_FFFF : sum[CYCLE_W-1:0];
   endfunction

   task automatic send_lookup();
      send_command(MODE_LOOKUP, OFFSET_W'($urandom), KEY_W'($urandom), pick_query());
   endtask

   task automatic send_clear();
      send_command(MODE_CLEAR, OFFSET_W'($urandom), KEY_W'($urandom), CYCLE_W'($urandom));
      next_offset = 0;
   endtask

   // cleared table built with rising offsets, mixed with lookups and noise
   task automatic random_phase(input int item_total, input int max_step);
      int unsigned pick;
      int          off;
      send_clear();
      repeat (item_total) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            off = next_offset + $urandom_range(max_step - 1);
            if (off > 1023) off = 1023;
            send_command(MODE_APPEND, OFFSET_W'(off), pick_key(), CYCLE_W'($urandom));
            if (off >= next_offset) next_offset = off + 1;
         end else if (pick < 82 || (next_offset == 0 && pick < 92)) begin
            send_lookup();
         end else if (pick < 92) begin
            // offset at or below the last stored one
            off = $urandom_range(next_offset - 1);
            send_command(MODE_APPEND, OFFSET_W'(off), KEY_W'($urandom), CYCLE_W'($urandom));
         end else if (pick < 97) begin
            send_command(MODE_SPARE, OFFSET_W'($urandom), KEY_W'($urandom), CYCLE_W'($urandom));
         end else begin
            send_clear();
         end
      end
   endtask

   // response side: random stalls, one long hold-off on request
   initial begin : response_pacing
      int stall;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_request = 1'b0;
         end
         stall = no_idle ? 0 : $urandom_range(19);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin : stimulus
      logic [CYCLE_W-1:0] base_choice;
      logic [KEY_W-1:0]   undef_choice;
      int                 off;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, spare kind, order errors, undefined key, chunk edges
      send_command(MODE_LOOKUP, 10'd0, 16'h0000, 31'd0);
      send_command(MODE_SPARE, 10'h3FF, 16'hFFFF, 31'h7FFF_FFFF);
      send_command(MODE_APPEND, 10'd5, 16'h1234, 31'd0);
      send_command(MODE_APPEND, 10'd5, 16'h4321, 31'd0);
      send_command(MODE_APPEND, 10'd3, 16'h5555, 31'd0);
      send_command(MODE_APPEND, 10'd10, 16'hFFFF, 31'd0);
      send_command(MODE_APPEND, 10'h3FF, 16'h0000, 31'd0);
      send_command(MODE_LOOKUP, 10'd0, 16'h0000, 31'd4);
      send_command(MODE_LOOKUP, 10'd0, 16'h0000, 31'd5);
      send_command(MODE_LOOKUP, 10'd0, 16'h0000, 31'd12);
      send_command(MODE_LOOKUP, 10'd0, 16'h0000, 31'd1023);
      send_command(MODE_LOOKUP, 10'h3FF, 16'hFFFF, 31'h7FFF_FFFF);
      send_command(MODE_APPEND, 10'h3FF, 16'hAAAA, 31'd0);
      send_command(MODE_CLEAR, 10'd0, 16'h0000, 31'd0);
      send_command(MODE_LOOKUP, 10'd0, 16'h0000, 31'd100);
      send_command(MODE_APPEND, 10'd0, 16'hFFFF, 31'd0);
      send_command(MODE_LOOKUP, 10'd0, 16'h0000, 31'd0);

      // directed: base at the top of the range, undefined key zero
      wait_idle();
      set_table_config(31'h7FFF_FFFF, 16'h0000);
      send_command(MODE_LOOKUP, 10'd0, 16'h0000, 31'd0);
      send_command(MODE_LOOKUP, 10'd0, 16'h0000, 31'h7FFF_FFFF);
      send_command(MODE_APPEND, 10'h3FF, 16'h0000, 31'd0);
      send_command(MODE_LOOKUP, 10'd0, 16'h0000, 31'h7FFF_FFFF);

      // full table: every offset of the chunk, then appends past the end
      wait_idle();
      set_table_config(CYCLE_W'($urandom_range(1000)), KEY_W'($urandom));
      send_clear();
      for (off = 0; off < 1024; off++) begin
         no_idle = (off < 512);
         send_command(MODE_APPEND, OFFSET_W'(off), pick_key(), CYCLE_W'($urandom));
         next_offset = off + 1;
         if (off % 40 == 0) send_lookup();
      end
      no_idle = 1'b0;
      repeat (3)
         send_command(MODE_APPEND, OFFSET_W'($urandom), KEY_W'($urandom), CYCLE_W'($urandom));
      repeat (20) send_lookup();
      send_command(MODE_LOOKUP, 10'd0, 16'h0000, cur_base + 31'd1023);

      // random phases over several register settings
      for (int phase = 0; phase < 7; phase++) begin
         wait_idle();
         case (phase % 4)
            0: base_choice = '0;
            1: base_choice = 31'h7FFF_FFFF - CYCLE_W'($urandom_range(600));
            2: base_choice = CYCLE_W'($urandom);
            default: base_choice = CYCLE_W'($urandom_range(5000));
         endcase
         case (phase % 3)
            0: undef_choice = 16'h0000;
            1: undef_choice = 16'hFFFF;
            default: undef_choice = KEY_W'($urandom);
         endcase
         set_table_config(base_choice, undef_choice);
         no_idle = (phase % 3 == 1);
         // receiver holds off while commands keep coming
         if (phase == 2) begin
            no_idle      = 1'b1;
            hold_request = 1'b1;
         end
         random_phase($urandom_range(12, 20), (phase % 2 == 0) ? 4 : 40);
      end
      no_idle = 1'b0;

      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && results_owed == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // run limit
   initial begin : watchdog
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
